// ===== hw/rtl/chri_pkg.sv =====
// shared constants, types and helpers of the counter hash random index block
package chri_pkg;

  localparam logic [31:0] HASH_SEED = 32'h243f6a88;
  localparam logic [31:0] ROUND_ADD = 32'h9e3779b9;
  localparam logic [31:0] ORD_MUL   = 32'h85ebca6b;
  localparam logic [31:0] ROUND_MUL = 32'hc2b2ae35;
  localparam logic [31:0] FIN_MUL_A = 32'h7feb352d;
  localparam logic [31:0] FIN_MUL_B = 32'h846ca68b;
  localparam logic [31:0] FINAL_XOR = 32'h13198a2e;
  localparam int unsigned ROT_AMOUNT = 13;

  localparam int unsigned ROUNDS      = 10;
  localparam int unsigned KEY_IN      = 8;
  localparam int unsigned FIN_STAGES  = 2;
  localparam int unsigned HASH_STAGES = ROUNDS + FIN_STAGES;
  localparam int unsigned DIV_STAGES  = 32;
  localparam int unsigned NUM_STAGES  = HASH_STAGES + DIV_STAGES;

  // configuration register indexes
  localparam logic REG_SIMULATION_EPOCH = 1'b0;
  localparam logic REG_MATCH_SEED       = 1'b1;

  // one stage of the remainder pipeline
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] num;
    logic [31:0] raw;
    logic [31:0] bound;
  } div_t;

  // per-round additive constant: golden ratio plus ordinal times the odd multiplier
  function automatic logic [31:0] round_const(input int unsigned k);
    logic [63:0] p;
    p = 64'(k) * 64'(ORD_MUL);
    return ROUND_ADD + p[31:0];
  endfunction

  function automatic logic [31:0] mix16(input logic [31:0] v);
    return v ^ (v >> 16);
  endfunction

endpackage

// ===== hw/rtl/chri_round_stage.sv =====
// one registered hash round: add, xor with rotate, multiply
module chri_round_stage (
  input  logic        clk,
  input  logic        ld,
  input  logic [31:0] s_in,
  input  logic [31:0] word,
  input  logic [31:0] rc,
  output logic [31:0] m
);
  import chri_pkg::*;

  logic [31:0] t;
  logic [31:0] u;

  always_comb begin
    t = s_in + word + rc;
    u = t ^ ((t << ROT_AMOUNT) | (t >> (32 - ROT_AMOUNT)));
  end

  // product register, xor-shift is folded into the next stage
  always_ff @(posedge clk) begin
    if (ld) begin
      m <= u * ROUND_MUL;
    end
  end

endmodule

// ===== hw/rtl/chri_div_stage.sv =====
// one registered bit of the restoring remainder pipeline
module chri_div_stage (
  input  logic          clk,
  input  logic          ld,
  input  chri_pkg::div_t d_in,
  output chri_pkg::div_t d_q
);
  import chri_pkg::*;

  logic [32:0] shifted;
  logic [32:0] diff;
  div_t        d_next;

  always_comb begin
    shifted = {d_in.rem, d_in.num[31]};
    diff    = shifted - {1'b0, d_in.bound};
    d_next  = d_in;
    d_next.num = {d_in.num[30:0], 1'b0};
    if (shifted >= {1'b0, d_in.bound}) begin
      d_next.rem = diff[31:0];
    end else begin
      d_next.rem = shifted[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      d_q <= d_next;
    end
  end

endmodule

// ===== hw/rtl/counter_hash_rng_index.sv =====
// top level of the counter hash random index block
// Stateless random draw: ten key words (two configuration registers, eight
// request words) are folded into a 32-bit hash, finalised, and reduced modulo
// upper_bound. One request is taken every clock cycle while in_stall is low;
// it passes through ten round stages, two finaliser stages and 32 remainder
// stages at one quotient bit each, then the output register. Every stage
// holds one multiplier or one 33-bit subtract and compare. Stages with no
// request in them fill up while the output is stalled, so requests keep
// being taken until the pipeline is full. A zero upper_bound gives ok low
// with zero raw_word and chosen_index. The user must write configuration through
// cfg_we / cfg_index / cfg_data while no request is in flight; it is not enforced.
module counter_hash_rng_index (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  // request side
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] frame_number,
  input  logic [31:0] stream_domain,
  input  logic [31:0] player_slot,
  input  logic [31:0] owner_id,
  input  logic [31:0] source_id,
  input  logic [31:0] event_type,
  input  logic [31:0] event_number,
  input  logic [31:0] draw_number,
  input  logic [31:0] upper_bound,
  // result side
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] raw_word,
  output logic [31:0] chosen_index,
  output logic        ok
);
  import chri_pkg::*;

  // configuration registers
  logic [31:0] simulation_epoch;
  logic [31:0] match_seed;

  always_ff @(posedge clk) begin
    if (rst) begin
      simulation_epoch <= '0;
      match_seed       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIMULATION_EPOCH: simulation_epoch <= cfg_data;
        REG_MATCH_SEED:       match_seed       <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage occupancy and backpressure
  // a stage may load when it is empty or its contents move on
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES:0]   rdy;

  always_comb begin
    rdy[NUM_STAGES] = !out_valid || !out_stall;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
      if (rdy[NUM_STAGES]) begin
        out_valid <= vld[NUM_STAGES-1];
      end
    end
  end

  // hash rounds, request words and bound ride along with the state
  logic [KEY_IN-1:0][31:0] key_in;
  logic [KEY_IN-1:0][31:0] key_src [ROUNDS];
  logic [KEY_IN-1:0][31:0] key     [ROUNDS];
  logic [31:0]             bnd_src [ROUNDS];
  logic [31:0]             bnd     [ROUNDS];
  logic [31:0]             rnd_s   [ROUNDS];
  logic [31:0]             rnd_w   [ROUNDS];
  logic [31:0]             rnd_m   [ROUNDS];

  assign key_in = {draw_number, event_number, event_type, source_id,
                   owner_id, player_slot, stream_domain, frame_number};

  for (genvar j = 0; j < ROUNDS; j++) begin : g_round
    if (j == 0) begin : g_first
      assign rnd_s[j]   = HASH_SEED;
      assign key_src[j] = key_in;
      assign bnd_src[j] = upper_bound;
    end else begin : g_next
      assign rnd_s[j]   = mix16(rnd_m[j-1]);
      assign key_src[j] = key[j-1];
      assign bnd_src[j] = bnd[j-1];
    end

    // first two key words come straight from configuration, which the user must keep stable in flight
    if (j == 0) begin : g_w_epoch
      assign rnd_w[j] = simulation_epoch;
    end else if (j == 1) begin : g_w_seed
      assign rnd_w[j] = match_seed;
    end else begin : g_w_key
      assign rnd_w[j] = key_src[j][j-2];
    end

    chri_round_stage u_round (
      .clk  (clk),
      .ld   (rdy[j]),
      .s_in (rnd_s[j]),
      .word (rnd_w[j]),
      .rc   (round_const(j)),
      .m    (rnd_m[j])
    );

    always_ff @(posedge clk) begin
      if (rdy[j]) begin
        key[j] <= key_src[j];
        bnd[j] <= bnd_src[j];
      end
    end
  end

  // finaliser, two multiply stages
  logic [31:0] fin_x1;
  logic [31:0] fin_x2;
  logic [31:0] fin_a;
  logic [31:0] fin_b;
  logic [31:0] bnd_fa;
  logic [31:0] bnd_fb;

  always_comb begin
    fin_x1 = mix16(rnd_m[ROUNDS-1]) ^ FINAL_XOR;
    fin_x1 = fin_x1 ^ (fin_x1 >> 16);
    fin_x2 = fin_a ^ (fin_a >> 15);
  end

  always_ff @(posedge clk) begin
    if (rdy[ROUNDS]) begin
      fin_a  <= fin_x1 * FIN_MUL_A;
      bnd_fa <= bnd[ROUNDS-1];
    end
    if (rdy[ROUNDS+1]) begin
      fin_b  <= fin_x2 * FIN_MUL_B;
      bnd_fb <= bnd_fa;
    end
  end

  // remainder pipeline, one quotient bit per stage
  div_t div_src [DIV_STAGES];
  div_t div_q   [DIV_STAGES];

  for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
    if (d == 0) begin : g_first
      always_comb begin
        div_src[d].rem   = '0;
        div_src[d].num   = mix16(fin_b);
        div_src[d].raw   = mix16(fin_b);
        div_src[d].bound = bnd_fb;
      end
    end else begin : g_next
      assign div_src[d] = div_q[d-1];
    end

    chri_div_stage u_div (
      .clk  (clk),
      .ld   (rdy[HASH_STAGES+d]),
      .d_in (div_src[d]),
      .d_q  (div_q[d])
    );
  end

  // output register, zero bound clears the result
  logic bound_ok;

  assign bound_ok = div_q[DIV_STAGES-1].bound != '0;

  always_ff @(posedge clk) begin
    if (rdy[NUM_STAGES]) begin
      ok           <= bound_ok;
      raw_word     <= bound_ok ? div_q[DIV_STAGES-1].raw : '0;
      chosen_index <= bound_ok ? div_q[DIV_STAGES-1].rem : '0;
    end
  end

endmodule
